// ===== rtl/tbf_pkg.sv =====
// Shared constants, request codes and the 5x8 glyph ROM of the text and bar framebuffer.
package tbf_pkg;

  localparam int unsigned FRAME_WIDTH = 128;
  localparam int unsigned FRAME_PAGES = 8;
  localparam int unsigned STORE_SIZE  = FRAME_WIDTH * FRAME_PAGES;

  localparam int unsigned ADDR_W = $clog2(STORE_SIZE);
  localparam int unsigned COL_W  = $clog2(FRAME_WIDTH);
  localparam int unsigned PAGE_W = (FRAME_PAGES > 1) ? $clog2(FRAME_PAGES) : 1;

  localparam logic [7:0] FIRST_CODE  = 8'h20;
  localparam logic [7:0] LAST_CODE   = 8'h7E;
  localparam logic [7:0] SUBST_CODE  = 8'h3F;
  localparam int unsigned CELL_WIDTH = 6;
  localparam logic [7:0] BORDER_BYTE = 8'h7E;
  localparam logic [7:0] FULL_BYTE   = 8'h3C;
  localparam logic [7:0] EMPTY_BYTE  = 8'h24;
  localparam logic [7:0] INV_MASK    = 8'hFF;
  localparam int unsigned BAR_SPAN    = 126;
  localparam int unsigned PERCENT_MAX = 100;

  localparam int unsigned GLYPH_COUNT = 95;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_CHAR  = 2'd1,
    REQ_BAR   = 2'd2,
    REQ_READ  = 2'd3
  } req_type_e;

  // One row per printable code from 0x20; leftmost column in the top byte.
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000,
    40'h0041360800, 40'h1008081008
  };

  function automatic logic [7:0] glyph_byte(input logic [6:0] idx, input logic [2:0] k);
    logic [39:0] row;
    logic [7:0]  res;
    row = GLYPH_ROM[idx];
    unique case (k)
      3'd0:    res = row[39:32];
      3'd1:    res = row[31:24];
      3'd2:    res = row[23:16];
      3'd3:    res = row[15:8];
      3'd4:    res = row[7:0];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/text_and_bar_framebuffer.sv =====
// Top level of the page framebuffer with character and progress bar drawing.
//
// Usage: present a request on req_type_i and its fields, raise start_i; the
// request transfers at a rising edge with start_i high and busy_o low.
// Requests and the passes they run after the transfer with busy_o high;
// clear, character and bar write one store byte per cycle through the
// single write port of the frame RAM, and the next request transfers only
// once the pass has ended and busy_o is low again:
//   clear      - STORE_SIZE bytes (1024), sweeps every byte to zero
//   character  - five glyph columns and one spacing column
//   bar        - FRAME_WIDTH bytes (128), one full page
//   read       - no store write; the byte comes from the registered RAM read and
//                appears on read_byte_o with valid_o high for exactly one
//                cycle, the cycle after the transfer
// A character off the right edge or on a page out of range, or a bar on a
// page out of range, is dropped and busy_o stays low.
// After reset the block runs a clearing pass over the whole store with busy_o
// high before it takes the first request. The receiver of results cannot
// stall: each result is taken in its strobe cycle.
module text_and_bar_framebuffer
  import tbf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] column_i,
  input  logic [7:0] page_row_i,
  input  logic [7:0] char_code_i,
  input  logic       inverse_i,
  input  logic [7:0] percent_i,
  output logic [7:0] read_byte_o,
  output logic       valid_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHAR,
    ST_BAR,
    ST_READ
  } state_e;

  localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(STORE_SIZE - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELL_WIDTH - 1);
  localparam logic [ADDR_W-1:0] BAR_LAST   = ADDR_W'(FRAME_WIDTH - 1);

  state_e            state_q;
  logic [ADDR_W-1:0] cnt_q;
  logic [ADDR_W-1:0] base_q;
  logic [6:0]        glyph_q;
  logic              inv_q;
  logic [14:0]       fill_q;
  logic              rd_ok_q;

  logic        accept;
  logic        page_ok;
  logic        char_fits;
  logic        col_ok;
  logic [7:0]  code_eff;
  logic [7:0]  pct_sat;
  logic [ADDR_W-1:0] page_base;
  logic [ADDR_W-1:0] req_addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  logic [7:0]        mask;
  logic [COL_W-1:0]  bar_col;
  logic              bar_border;
  logic              bar_full;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign page_ok   = page_row_i < 8'(FRAME_PAGES);
  assign char_fits = (10'(column_i) + 10'(CELL_WIDTH)) <= 10'(FRAME_WIDTH);
  assign col_ok    = 9'(column_i) < 9'(FRAME_WIDTH);
  assign code_eff  = (char_code_i < FIRST_CODE || char_code_i > LAST_CODE) ?
                     SUBST_CODE : char_code_i;
  assign pct_sat   = (percent_i > 8'(PERCENT_MAX)) ? 8'(PERCENT_MAX) : percent_i;
  assign page_base = ADDR_W'(page_row_i[PAGE_W-1:0]) * ADDR_W'(FRAME_WIDTH);
  assign req_addr  = page_base + ADDR_W'(column_i[COL_W-1:0]);

  // Fill test c <= pct*126/100 rewritten as c*100 <= pct*126.
  assign bar_col    = cnt_q[COL_W-1:0];
  assign bar_border = (cnt_q == '0) || (cnt_q == BAR_LAST);
  assign bar_full   = (15'(bar_col) * 15'(PERCENT_MAX)) <= fill_q;
  assign mask       = inv_q ? INV_MASK : 8'h00;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 8'h00;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_CHAR: begin
        ram_we    = 1'b1;
        ram_wdata = (cnt_q == CELL_LAST) ? mask : (glyph_byte(glyph_q, cnt_q[2:0]) ^ mask);
      end
      ST_BAR: begin
        ram_we    = 1'b1;
        ram_wdata = bar_border ? BORDER_BYTE : (bar_full ? FULL_BYTE : EMPTY_BYTE);
      end
      ST_IDLE, ST_READ: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_waddr = base_q + cnt_q;
  assign ram_re    = accept && (req_type_i == REQ_READ);

  tbf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (req_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      base_q  <= '0;
      glyph_q <= '0;
      inv_q   <= 1'b0;
      fill_q  <= '0;
      rd_ok_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CLEAR_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_CHAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CELL_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_BAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == BAR_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            unique case (req_type_e'(req_type_i))
              REQ_CLEAR: begin
                base_q  <= '0;
                state_q <= ST_CLEAR;
              end
              REQ_CHAR: begin
                base_q  <= req_addr;
                glyph_q <= 7'(code_eff - FIRST_CODE);
                inv_q   <= inverse_i;
                // drop a cell that runs off the edge or a bad page
                if (page_ok && char_fits) begin
                  state_q <= ST_CHAR;
                end
              end
              REQ_BAR: begin
                base_q <= page_base;
                fill_q <= 15'(pct_sat) * 15'(BAR_SPAN);
                if (page_ok) begin
                  state_q <= ST_BAR;
                end
              end
              REQ_READ: begin
                rd_ok_q <= page_ok && col_ok;
                valid_o <= 1'b1;
                state_q <= ST_READ;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign read_byte_o = rd_ok_q ? ram_rdata : 8'h00;

  // A result strobe only follows a read transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o && (req_type_i == REQ_READ)))
    else $error("result strobe without a read transfer");

  // The read result cycle never takes a new request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("request could transfer during a read result");

  // No store write while idle or returning a read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_READ) |-> !ram_we)
    else $error("store written outside a drawing pass");

  // A character cell never walks past its sixth column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHAR) |-> (cnt_q <= CELL_LAST))
    else $error("character pass ran past its cell");

  // The strobe lasts exactly one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held longer than one cycle");

endmodule

// ===== rtl/tbf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module tbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/tbf_checker.sv =====
`timescale 1ns / 100ps
// Checker for the text and bar framebuffer: keeps a copy of the frame store and checks reads.
module tbf_checker
  import tbf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  column_i,
  input  logic [7:0]  page_row_i,
  input  logic [7:0]  char_code_i,
  input  logic        inverse_i,
  input  logic [7:0]  percent_i,
  input  logic [7:0]  read_byte_i,
  input  logic        valid_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_reads_o
);

  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned CELL_COLS  = 6;
  localparam int unsigned BAR_COLS   = 126;
  localparam int unsigned FULL_SCALE = 100;

  localparam logic [7:0] SPACE_CODE    = 8'h20;
  localparam logic [7:0] TILDE_CODE    = 8'h7E;
  localparam logic [7:0] QUESTION_CODE = 8'h3F;
  localparam logic [7:0] BORDER_COL    = 8'h7E;
  localparam logic [7:0] FILLED_COL    = 8'h3C;
  localparam logic [7:0] HOLLOW_COL    = 8'h24;

  // Five columns per printable code from the space upward, leftmost in the top byte.
  localparam logic [39:0] FONT [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  logic [7:0] frame_copy [STORE_SIZE];
  logic [7:0] read_bytes_due [$];
  int unsigned errors;

  function automatic void paint_char(input int unsigned col, input int unsigned page,
                                     input logic [7:0] code, input logic inv);
    logic [7:0]  sym;
    logic [7:0]  mask;
    logic [39:0] glyph;
    int unsigned base;
    sym  = code;
    mask = inv ? 8'hFF : 8'h00;
    if (sym < SPACE_CODE || sym > TILDE_CODE) sym = QUESTION_CODE;
    // drop cells that do not fit
    if (col + CELL_COLS > FRAME_WIDTH || page >= FRAME_PAGES) return;
    glyph = FONT[sym - SPACE_CODE];
    base  = page * FRAME_WIDTH + col;
    for (int k = 0; k < 5; k++) frame_copy[base + k] = glyph[39 - 8 * k -: 8] ^ mask;
    frame_copy[base + 5] = mask;
  endfunction

  function automatic void paint_bar(input int unsigned page, input int unsigned pct);
    int unsigned level;
    int unsigned fill;
    level = (pct > FULL_SCALE) ? FULL_SCALE : pct;
    if (page >= FRAME_PAGES) return;
    fill = level * BAR_COLS / FULL_SCALE;
    for (int unsigned c = 0; c < FRAME_WIDTH; c++) begin
      if (c == 0 || c == FRAME_WIDTH - 1) frame_copy[page * FRAME_WIDTH + c] = BORDER_COL;
      else frame_copy[page * FRAME_WIDTH + c] = (c <= fill) ? FILLED_COL : HOLLOW_COL;
    end
  endfunction

  function automatic logic [7:0] fetch_byte(input int unsigned col, input int unsigned page);
    if (col < FRAME_WIDTH && page < FRAME_PAGES) return frame_copy[page * FRAME_WIDTH + col];
    return 8'h00;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    if (!rst_ni) begin
      foreach (frame_copy[i]) frame_copy[i] = 8'h00;
      read_bytes_due.delete();
      errors = 0;
      mismatch_count_o <= 0;
      pending_reads_o  <= 0;
    end else begin
      // compare the result first: it belongs to a transfer at an earlier edge
      if (valid_i !== 1'b0) begin
        if (read_bytes_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("[%0t] read result 0x%02h with no read pending", $time, read_byte_i);
        end else begin
          want = read_bytes_due.pop_front();
          if (valid_i !== 1'b1 || read_byte_i !== want) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("[%0t] read_byte mismatch: expected 0x%02h, got 0x%02h (valid %b)",
                       $time, want, read_byte_i, valid_i);
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        case (req_type_e'(req_type_i))
          REQ_CLEAR: foreach (frame_copy[i]) frame_copy[i] = 8'h00;
          REQ_CHAR:  paint_char(column_i, page_row_i, char_code_i, inverse_i);
          REQ_BAR:   paint_bar(page_row_i, percent_i);
          REQ_READ:  read_bytes_due.push_back(fetch_byte(column_i, page_row_i));
          default:   ;
        endcase
      end
      mismatch_count_o <= errors;
      pending_reads_o  <= read_bytes_due.size();
    end
  end

endmodule

// ===== dv/tb_text_and_bar_framebuffer.sv =====
`timescale 1ns / 100ps
// Testbench top for the text and bar framebuffer: clock, reset, request stimulus and verdict.
module tb_text_and_bar_framebuffer
  import tbf_pkg::*;
;

  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned CYCLE_LIMIT  = 6_000_000;
  localparam int unsigned DRAIN_LIMIT  = 4096;
  localparam int unsigned CELL_COLS    = 6;
  localparam int unsigned MAX_IDLE     = 16;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start_i     = 1'b0;
  logic [1:0] req_type_i  = REQ_CLEAR;
  logic [7:0] column_i    = 8'h00;
  logic [7:0] page_row_i  = 8'h00;
  logic [7:0] char_code_i = 8'h00;
  logic       inverse_i   = 1'b0;
  logic [7:0] percent_i   = 8'h00;
  logic       busy_o;
  logic [7:0] read_byte_o;
  logic       valid_o;

  int unsigned mismatch_count;
  int unsigned pending_reads;
  int unsigned idle_pct = 0;
  int unsigned cycle_count = 0;

  text_and_bar_framebuffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_type_i  (req_type_i),
    .column_i    (column_i),
    .page_row_i  (page_row_i),
    .char_code_i (char_code_i),
    .inverse_i   (inverse_i),
    .percent_i   (percent_i),
    .read_byte_o (read_byte_o),
    .valid_o     (valid_o)
  );

  tbf_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .req_type_i       (req_type_i),
    .column_i         (column_i),
    .page_row_i       (page_row_i),
    .char_code_i      (char_code_i),
    .inverse_i        (inverse_i),
    .percent_i        (percent_i),
    .read_byte_i      (read_byte_o),
    .valid_i          (valid_o),
    .mismatch_count_o (mismatch_count),
    .pending_reads_o  (pending_reads)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one request and return at the edge where it transfers.
  task automatic send_request(input req_type_e kind, input logic [7:0] col,
                              input logic [7:0] page, input logic [7:0] code,
                              input logic inv, input logic [7:0] pct);
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < MAX_IDLE && $urandom_range(99) < idle_pct) idle_cycles++;
    if (idle_cycles != 0) begin
      // drop start and scramble the fields while idle
      start_i     <= 1'b0;
      req_type_i  <= 2'($urandom_range(3));
      column_i    <= 8'($urandom_range(255));
      page_row_i  <= 8'($urandom_range(255));
      char_code_i <= 8'($urandom_range(255));
      inverse_i   <= 1'($urandom_range(1));
      percent_i   <= 8'($urandom_range(255));
      repeat (idle_cycles) @(posedge clk_i);
    end
    req_type_i  <= kind;
    column_i    <= col;
    page_row_i  <= page;
    char_code_i <= code;
    inverse_i   <= inv;
    percent_i   <= pct;
    start_i     <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Mostly well-formed draws and reads on the visible area, with some off-range noise.
  task automatic random_request(output bit effective);
    req_type_e   kind;
    logic [7:0]  col;
    logic [7:0]  page;
    logic [7:0]  code;
    logic [7:0]  pct;
    logic        inv;
    int unsigned pick;
    pick = $urandom_range(99);
    col  = 8'($urandom_range(255));
    page = 8'($urandom_range(255));
    code = 8'($urandom_range(255));
    pct  = 8'($urandom_range(255));
    inv  = 1'($urandom_range(1));
    if (pick < 2) begin
      kind = REQ_CLEAR;
    end else if (pick < 12) begin
      kind = REQ_BAR;
      if ($urandom_range(9) != 0) page = 8'($urandom_range(FRAME_PAGES - 1));
      if ($urandom_range(9) < 6) pct = 8'($urandom_range(100));
    end else if (pick < 55) begin
      kind = REQ_CHAR;
      if ($urandom_range(99) < 85) col = 8'($urandom_range(FRAME_WIDTH - CELL_COLS));
      if ($urandom_range(9) != 0) page = 8'($urandom_range(FRAME_PAGES - 1));
      if ($urandom_range(9) < 7) code = 8'($urandom_range(8'h7E, 8'h20));
    end else begin
      kind = REQ_READ;
      if ($urandom_range(9) < 8) col = 8'($urandom_range(FRAME_WIDTH - 1));
      if ($urandom_range(9) != 0) page = 8'($urandom_range(FRAME_PAGES - 1));
    end
    effective = !((kind == REQ_CHAR && (int'(col) + CELL_COLS > FRAME_WIDTH ||
                                        page >= FRAME_PAGES)) ||
                  (kind == REQ_BAR && page >= FRAME_PAGES));
    send_request(kind, col, page, code, inv, pct);
  endtask

  initial begin
    int unsigned done_items;
    int unsigned drain;
    bit          effective;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty store, glyph edges, inversion, substitution, bar extremes, range
    send_request(REQ_READ,  8'd0,   8'd0,   8'h00, 1'b0, 8'd0);
    send_request(REQ_CHAR,  8'd0,   8'd0,   8'h41, 1'b0, 8'd0);
    send_request(REQ_READ,  8'd0,   8'd0,   8'h00, 1'b0, 8'd0);
    send_request(REQ_READ,  8'd5,   8'd0,   8'h00, 1'b0, 8'd0);
    send_request(REQ_CHAR,  8'd122, 8'd7,   8'h7E, 1'b1, 8'd0);
    send_request(REQ_READ,  8'd122, 8'd7,   8'h00, 1'b0, 8'd0);
    send_request(REQ_READ,  8'd127, 8'd7,   8'h00, 1'b0, 8'd0);
    send_request(REQ_CHAR,  8'd123, 8'd0,   8'h20, 1'b1, 8'd0);
    send_request(REQ_READ,  8'd123, 8'd0,   8'h00, 1'b0, 8'd0);
    send_request(REQ_CHAR,  8'd10,  8'd8,   8'h42, 1'b1, 8'd0);
    send_request(REQ_CHAR,  8'd6,   8'd1,   8'h1F, 1'b0, 8'd0);
    send_request(REQ_READ,  8'd6,   8'd1,   8'h00, 1'b0, 8'd0);
    send_request(REQ_CHAR,  8'd12,  8'd1,   8'hFF, 1'b1, 8'd0);
    send_request(REQ_READ,  8'd13,  8'd1,   8'h00, 1'b0, 8'd0);
    send_request(REQ_BAR,   8'd0,   8'd3,   8'h00, 1'b0, 8'd0);
    send_request(REQ_READ,  8'd1,   8'd3,   8'h00, 1'b0, 8'd0);
    send_request(REQ_BAR,   8'd0,   8'd4,   8'h00, 1'b0, 8'd255);
    send_request(REQ_READ,  8'd126, 8'd4,   8'h00, 1'b0, 8'd0);
    send_request(REQ_BAR,   8'd0,   8'd5,   8'h00, 1'b0, 8'd50);
    send_request(REQ_READ,  8'd63,  8'd5,   8'h00, 1'b0, 8'd0);
    send_request(REQ_READ,  8'd64,  8'd5,   8'h00, 1'b0, 8'd0);
    send_request(REQ_BAR,   8'd0,   8'd255, 8'h00, 1'b0, 8'd100);
    send_request(REQ_READ,  8'd255, 8'd255, 8'h00, 1'b0, 8'd0);
    send_request(REQ_READ,  8'd128, 8'd0,   8'h00, 1'b0, 8'd0);
    send_request(REQ_CLEAR, 8'd0,   8'd0,   8'h00, 1'b0, 8'd0);
    send_request(REQ_READ,  8'd0,   8'd0,   8'h00, 1'b0, 8'd0);

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (done_items < RANDOM_ITEMS / 3) idle_pct = 20;
      else if (done_items < 2 * RANDOM_ITEMS / 3) idle_pct = 50;
      else idle_pct = 0;
      random_request(effective);
      if (effective) done_items++;
    end
    start_i <= 1'b0;

    drain = 0;
    while ((pending_reads != 0 || busy_o !== 1'b0) && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (16) @(posedge clk_i);

    if (mismatch_count == 0 && pending_reads == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tbf_pkg.sv
rtl/tbf_ram.sv
rtl/text_and_bar_framebuffer.sv
dv/tbf_checker.sv
dv/tb_text_and_bar_framebuffer.sv
